### sv/dtpc_pkg.sv
// Shared types, constants and a helper function of the disparity to point cloud core.
`default_nettype none
package dtpc_pkg;

  localparam int CoordBits       = 12;
  localparam int ImgBits         = CoordBits + 1;
  localparam int StepBits        = 8;
  localparam int ModBitsPerStage = 4;
  localparam int ModStages       = CoordBits / ModBitsPerStage;
  localparam int DispBits        = 15;
  localparam int FbBits          = 32;
  localparam int DepthBits       = 17;
  localparam int FocalBits       = 16;
  localparam int NumBits         = 36;
  localparam int MagBits         = 35;
  localparam int OutBits         = 24;
  localparam int FifoDepth       = 4;
  localparam int FifoPtrBits     = $clog2(FifoDepth);

  localparam logic [StepBits-1:0]  MinStep  = 8'd2;
  localparam logic [DepthBits-1:0] DepthMin = 17'd100;
  localparam logic [DepthBits-1:0] DepthMax = 17'd100000;

  typedef enum logic [2:0] {
    RegStep, RegLeft, RegTop, RegFocalX, RegFocalY, RegCenterX, RegCenterY, RegBaseline
  } reg_e;

  typedef struct packed {
    logic [StepBits-1:0]  sample_step;
    logic [CoordBits-1:0] roi_left;
    logic [CoordBits-1:0] roi_top;
    logic [FocalBits-1:0] focal_x;
    logic [FocalBits-1:0] focal_y;
    logic [FocalBits-1:0] center_x;
    logic [FocalBits-1:0] center_y;
    logic [FocalBits-1:0] baseline_mm;
  } cfg_t;

  typedef struct packed {
    logic [ImgBits-1:0]  row_img;
    logic [ImgBits-1:0]  col_img;
    logic [DispBits-1:0] disp;
  } item_t;

  // ModBitsPerStage (4) bits of restoring remainder per call
  function automatic logic [StepBits-1:0] mod_step(input logic [StepBits-1:0] rem,
                                                   input logic [ModBitsPerStage-1:0] bits,
                                                   input logic [StepBits-1:0] div);
    logic [StepBits:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < ModBitsPerStage; i++) begin
      t = {t[StepBits-1:0], bits[ModBitsPerStage-1-i]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
    end
    return t[StepBits-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/dtpc_front.sv
// Front end: accepts pixels, runs the grid test and forwards kept pixels to the queue.
`default_nettype none
module dtpc_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  dtpc_pkg::cfg_t                        cfg_i,
  input  wire                                   push_i,
  output logic                                  full_o,
  input  wire  [dtpc_pkg::CoordBits-1:0]        region_row_i,
  input  wire  [dtpc_pkg::CoordBits-1:0]        region_col_i,
  input  wire  [7:0]                            mask_value_i,
  input  wire  signed [15:0]                    disparity_raw_i,
  input  wire                                   disparity_nan_i,
  output logic                                  q_push_o,
  output dtpc_pkg::item_t                       q_item_o,
  input  wire                                   q_full_i
);
  localparam int L = dtpc_pkg::ModStages;

  logic [L:0]                          vld_q;
  logic                                keep_q [0:L];
  logic [dtpc_pkg::CoordBits-1:0]      row_q  [0:L];
  logic [dtpc_pkg::CoordBits-1:0]      col_q  [0:L];
  logic [dtpc_pkg::StepBits-1:0]       rrem_q [0:L];
  logic [dtpc_pkg::StepBits-1:0]       crem_q [0:L];
  logic [dtpc_pkg::DispBits-1:0]       disp_q [0:L];
  logic [dtpc_pkg::StepBits-1:0]       step_eff;
  logic                                keep_in, pass, adv;

  assign step_eff = (cfg_i.sample_step < dtpc_pkg::MinStep) ? dtpc_pkg::MinStep
                                                             : cfg_i.sample_step;
  assign keep_in  = (mask_value_i != 8'd0) && !disparity_nan_i && !disparity_raw_i[15] &&
                    (disparity_raw_i[14:0] != 15'd0);
  assign pass     = keep_q[L] && (rrem_q[L] == '0) && (crem_q[L] == '0);
  assign adv      = !(vld_q[L] && pass && q_full_i);
  assign full_o   = !adv;
  assign q_push_o = vld_q[L] && pass && !q_full_i;

  assign q_item_o.row_img = {1'b0, row_q[L]} + {1'b0, cfg_i.roi_top};
  assign q_item_o.col_img = {1'b0, col_q[L]} + {1'b0, cfg_i.roi_left};
  assign q_item_o.disp    = disp_q[L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-1:0], push_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      keep_q[0] <= keep_in;
      row_q[0]  <= region_row_i;
      col_q[0]  <= region_col_i;
      rrem_q[0] <= '0;
      crem_q[0] <= '0;
      disp_q[0] <= disparity_raw_i[14:0];
      for (int s = 0; s < L; s++) begin
        keep_q[s+1] <= keep_q[s];
        row_q[s+1]  <= row_q[s];
        col_q[s+1]  <= col_q[s];
        disp_q[s+1] <= disp_q[s];
        rrem_q[s+1] <= dtpc_pkg::mod_step(rrem_q[s],
          row_q[s][dtpc_pkg::CoordBits-1-dtpc_pkg::ModBitsPerStage*s -:
                   dtpc_pkg::ModBitsPerStage], step_eff);
        crem_q[s+1] <= dtpc_pkg::mod_step(crem_q[s],
          col_q[s][dtpc_pkg::CoordBits-1-dtpc_pkg::ModBitsPerStage*s -:
                   dtpc_pkg::ModBitsPerStage], step_eff);
      end
    end
  end

endmodule
`default_nettype wire

### sv/dtpc_fifo.sv
// Short queue of kept pixels between front and back end.
`default_nettype none
module dtpc_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  dtpc_pkg::item_t  data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             empty_o,
  output dtpc_pkg::item_t  data_o
);
  dtpc_pkg::item_t                      mem_q [0:dtpc_pkg::FifoDepth-1];
  logic [dtpc_pkg::FifoPtrBits-1:0]     wr_q, rd_q;
  logic [dtpc_pkg::FifoPtrBits:0]       cnt_q;
  logic                                 do_push, do_pop;

  assign full_o  = (cnt_q == (dtpc_pkg::FifoPtrBits+1)'(dtpc_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (dtpc_pkg::FifoPtrBits+1)'(dtpc_pkg::FifoDepth))
    else $error("queue count above depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[dtpc_pkg::FifoPtrBits-1:0])
    else $error("queue pointers disagree with count");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule
`default_nettype wire

### sv/dtpc_back.sv
// Back end: depth divider, projection multipliers and x/y dividers with saturation.
`default_nettype none
module dtpc_back (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  dtpc_pkg::cfg_t                      cfg_i,
  input  wire                                 q_empty_i,
  input  dtpc_pkg::item_t                     q_item_i,
  output logic                                q_pop_o,
  output logic                                empty_o,
  input  wire                                 pop_i,
  output logic signed [dtpc_pkg::OutBits-1:0] x_mm_o,
  output logic signed [dtpc_pkg::OutBits-1:0] y_mm_o,
  output logic [dtpc_pkg::DepthBits-1:0]      depth_mm_o
);
  localparam int DB = dtpc_pkg::DepthBits;
  localparam int OB = dtpc_pkg::OutBits;
  localparam int FB = dtpc_pkg::FocalBits;
  localparam int DW = dtpc_pkg::DispBits;
  localparam int IB = dtpc_pkg::ImgBits;
  localparam int MB = dtpc_pkg::MagBits;

  function automatic logic [OB-1:0] finish(input logic neg, input logic zero,
                                           input logic sat, input logic [OB-1:0] q);
    logic [OB-1:0] r;
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (sat || q[OB-1]) ? {1'b0, {(OB-1){1'b1}}} : q;
    end else begin
      r = (sat || (q > {1'b1, {(OB-1){1'b0}}})) ? {1'b1, {(OB-1){1'b0}}} : (~q + 1'b1);
    end
    return r;
  endfunction

  logic adv;

  // input stage with focal times baseline
  logic                s0_vld_q;
  logic [dtpc_pkg::FbBits-1:0] s0_fb_q;
  logic [IB-1:0]       s0_row_q, s0_col_q;
  logic [DW-1:0]       s0_disp_q;

  // depth divider
  logic [DB:0]         d_vld_q;
  logic                d_ok_q   [0:DB];
  logic [DW-1:0]       d_rem_q  [0:DB];
  logic [DB-1:0]       d_q_q    [0:DB];
  logic [DB-1:0]       d_lo_q   [0:DB];
  logic [DW-1:0]       d_disp_q [0:DB];
  logic [IB-1:0]       d_row_q  [0:DB];
  logic [IB-1:0]       d_col_q  [0:DB];

  // products
  logic                m_vld_q;
  logic [DB-1:0]       m_depth_q;
  logic signed [dtpc_pkg::NumBits-1:0] m_nx_q, m_ny_q;
  logic [dtpc_pkg::NumBits-1:0] ax, ay;
  logic signed [IB+5:0] dx, dy;

  // x and y dividers
  logic [OB:0]         x_vld_q;
  logic [DB-1:0]       x_depth_q [0:OB];
  logic                xn_q [0:OB], xz_q [0:OB], xs_q [0:OB];
  logic                yn_q [0:OB], yz_q [0:OB], ys_q [0:OB];
  logic [FB-1:0]       xr_q [0:OB], yr_q [0:OB];
  logic [OB-1:0]       xq_q [0:OB], yq_q [0:OB];
  logic [OB-1:0]       xl_q [0:OB], yl_q [0:OB];

  // output register
  logic                out_vld_q;
  logic [OB-1:0]       x_q, y_q;
  logic [DB-1:0]       depth_q;

  assign adv        = !out_vld_q || pop_i;
  assign q_pop_o    = adv && !q_empty_i;
  assign empty_o    = !out_vld_q;
  assign x_mm_o     = x_q;
  assign y_mm_o     = y_q;
  assign depth_mm_o = depth_q;

  assign dx = $signed({1'b0, d_col_q[DB], 4'b0}) - $signed({2'b0, cfg_i.center_x});
  assign dy = $signed({1'b0, d_row_q[DB], 4'b0}) - $signed({2'b0, cfg_i.center_y});
  assign ax = m_nx_q[dtpc_pkg::NumBits-1] ? (~m_nx_q + 1'b1) : m_nx_q;
  assign ay = m_ny_q[dtpc_pkg::NumBits-1] ? (~m_ny_q + 1'b1) : m_ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      d_vld_q   <= '0;
      m_vld_q   <= 1'b0;
      x_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q  <= !q_empty_i;
      d_vld_q   <= {d_vld_q[DB-1:0], s0_vld_q};
      m_vld_q   <= d_vld_q[DB] && d_ok_q[DB] && (d_q_q[DB] > dtpc_pkg::DepthMin) &&
                   (d_q_q[DB] <= dtpc_pkg::DepthMax);
      x_vld_q   <= {x_vld_q[OB-1:0], m_vld_q};
      out_vld_q <= x_vld_q[OB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_fb_q   <= cfg_i.focal_x * cfg_i.baseline_mm;
      s0_row_q  <= q_item_i.row_img;
      s0_col_q  <= q_item_i.col_img;
      s0_disp_q <= q_item_i.disp;

      d_ok_q[0]   <= s0_fb_q < {s0_disp_q, {DB{1'b0}}};
      d_rem_q[0]  <= s0_fb_q[dtpc_pkg::FbBits-1:DB];
      d_lo_q[0]   <= s0_fb_q[DB-1:0];
      d_q_q[0]    <= '0;
      d_disp_q[0] <= s0_disp_q;
      d_row_q[0]  <= s0_row_q;
      d_col_q[0]  <= s0_col_q;
      for (int k = 0; k < DB; k++) begin
        d_ok_q[k+1]   <= d_ok_q[k];
        d_lo_q[k+1]   <= d_lo_q[k];
        d_disp_q[k+1] <= d_disp_q[k];
        d_row_q[k+1]  <= d_row_q[k];
        d_col_q[k+1]  <= d_col_q[k];
        if ({d_rem_q[k], d_lo_q[k][DB-1-k]} >= {1'b0, d_disp_q[k]}) begin
          d_rem_q[k+1] <= DW'({d_rem_q[k], d_lo_q[k][DB-1-k]} - {1'b0, d_disp_q[k]});
          d_q_q[k+1]   <= {d_q_q[k][DB-2:0], 1'b1};
        end else begin
          d_rem_q[k+1] <= DW'({d_rem_q[k], d_lo_q[k][DB-1-k]});
          d_q_q[k+1]   <= {d_q_q[k][DB-2:0], 1'b0};
        end
      end

      m_depth_q <= d_q_q[DB];
      m_nx_q    <= dx * $signed({1'b0, d_q_q[DB]});
      m_ny_q    <= dy * $signed({1'b0, d_q_q[DB]});

      x_depth_q[0] <= m_depth_q;
      xn_q[0] <= m_nx_q[dtpc_pkg::NumBits-1];
      yn_q[0] <= m_ny_q[dtpc_pkg::NumBits-1];
      xz_q[0] <= (m_nx_q == '0);
      yz_q[0] <= (m_ny_q == '0);
      xs_q[0] <= {5'b0, ax[MB-1:0]} >= {cfg_i.focal_x, {OB{1'b0}}};
      ys_q[0] <= {5'b0, ay[MB-1:0]} >= {cfg_i.focal_y, {OB{1'b0}}};
      xr_q[0] <= FB'(ax[MB-1:OB]);
      yr_q[0] <= FB'(ay[MB-1:OB]);
      xl_q[0] <= ax[OB-1:0];
      yl_q[0] <= ay[OB-1:0];
      xq_q[0] <= '0;
      yq_q[0] <= '0;
      for (int k = 0; k < OB; k++) begin
        x_depth_q[k+1] <= x_depth_q[k];
        xn_q[k+1] <= xn_q[k];
        yn_q[k+1] <= yn_q[k];
        xz_q[k+1] <= xz_q[k];
        yz_q[k+1] <= yz_q[k];
        xs_q[k+1] <= xs_q[k];
        ys_q[k+1] <= ys_q[k];
        xl_q[k+1] <= xl_q[k];
        yl_q[k+1] <= yl_q[k];
        if ({xr_q[k], xl_q[k][OB-1-k]} >= {1'b0, cfg_i.focal_x}) begin
          xr_q[k+1] <= FB'({xr_q[k], xl_q[k][OB-1-k]} - {1'b0, cfg_i.focal_x});
          xq_q[k+1] <= {xq_q[k][OB-2:0], 1'b1};
        end else begin
          xr_q[k+1] <= FB'({xr_q[k], xl_q[k][OB-1-k]});
          xq_q[k+1] <= {xq_q[k][OB-2:0], 1'b0};
        end
        if ({yr_q[k], yl_q[k][OB-1-k]} >= {1'b0, cfg_i.focal_y}) begin
          yr_q[k+1] <= FB'({yr_q[k], yl_q[k][OB-1-k]} - {1'b0, cfg_i.focal_y});
          yq_q[k+1] <= {yq_q[k][OB-2:0], 1'b1};
        end else begin
          yr_q[k+1] <= FB'({yr_q[k], yl_q[k][OB-1-k]});
          yq_q[k+1] <= {yq_q[k][OB-2:0], 1'b0};
        end
      end

      x_q     <= finish(xn_q[OB], xz_q[OB], xs_q[OB], xq_q[OB]);
      y_q     <= finish(yn_q[OB], yz_q[OB], ys_q[OB], yq_q[OB]);
      depth_q <= x_depth_q[OB];
    end
  end

  a_depth_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (depth_q > dtpc_pkg::DepthMin) && (depth_q <= dtpc_pkg::DepthMax))
    else $error("depth outside band on output");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("pop from empty queue");
  a_zero_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && x_vld_q[OB] && xz_q[OB]) |=> (x_q == '0))
    else $error("zero numerator gave nonzero x");

endmodule
`default_nettype wire

### sv/disparity_to_point_cloud_core.sv
// Top level: configuration registers, front end, pixel queue and back end.
// Throughput: one pixel per cycle unless stalled; grid test and dividers are fully pipelined.
// Back pressure: the back pipeline holds while a result waits; the queue absorbs 4 pixels.
// Reset: asynchronous, active low; clears all valid flags and loads register defaults.
`default_nettype none
module disparity_to_point_cloud_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [2:0]                          cfg_idx_i,
  input  wire  [15:0]                         cfg_data_i,
  input  wire                                 push,
  output logic                                full,
  input  wire  [11:0]                         region_row_i,
  input  wire  [11:0]                         region_col_i,
  input  wire  [7:0]                          mask_value_i,
  input  wire  signed [15:0]                  disparity_raw_i,
  input  wire                                 disparity_nan_i,
  output logic                                empty,
  input  wire                                 pop,
  output logic signed [23:0]                  x_mm_o,
  output logic signed [23:0]                  y_mm_o,
  output logic [16:0]                         depth_mm_o
);
  dtpc_pkg::cfg_t  cfg_q;
  dtpc_pkg::item_t f_item, q_item;
  logic            f_push, q_full, q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_step <= 8'd2;
      cfg_q.roi_left    <= '0;
      cfg_q.roi_top     <= '0;
      cfg_q.focal_x     <= 16'd8000;
      cfg_q.focal_y     <= 16'd8000;
      cfg_q.center_x    <= 16'd5120;
      cfg_q.center_y    <= 16'd3840;
      cfg_q.baseline_mm <= 16'd120;
    end else if (cfg_we_i) begin
      unique case (dtpc_pkg::reg_e'(cfg_idx_i))
        dtpc_pkg::RegStep:     cfg_q.sample_step <= cfg_data_i[7:0];
        dtpc_pkg::RegLeft:     cfg_q.roi_left    <= cfg_data_i[11:0];
        dtpc_pkg::RegTop:      cfg_q.roi_top     <= cfg_data_i[11:0];
        dtpc_pkg::RegFocalX:   cfg_q.focal_x     <= cfg_data_i;
        dtpc_pkg::RegFocalY:   cfg_q.focal_y     <= cfg_data_i;
        dtpc_pkg::RegCenterX:  cfg_q.center_x    <= cfg_data_i;
        dtpc_pkg::RegCenterY:  cfg_q.center_y    <= cfg_data_i;
        dtpc_pkg::RegBaseline: cfg_q.baseline_mm <= cfg_data_i;
        default:               cfg_q.baseline_mm <= cfg_data_i;
      endcase
    end
  end

  dtpc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .push_i          (push),
    .full_o          (full),
    .region_row_i    (region_row_i),
    .region_col_i    (region_col_i),
    .mask_value_i    (mask_value_i),
    .disparity_raw_i (disparity_raw_i),
    .disparity_nan_i (disparity_nan_i),
    .q_push_o        (f_push),
    .q_item_o        (f_item),
    .q_full_i        (q_full)
  );

  dtpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_item)
  );

  dtpc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .x_mm_o     (x_mm_o),
    .y_mm_o     (y_mm_o),
    .depth_mm_o (depth_mm_o)
  );

endmodule
`default_nettype wire

### bench/disparity_to_point_cloud_core_test.sv
// Self-checking testbench for the disparity to point cloud core: directed table, then random phases.
`default_nettype none
module disparity_to_point_cloud_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 60;

  typedef struct packed {
    logic [11:0]        row;
    logic [11:0]        col;
    logic [7:0]         mask;
    logic signed [15:0] disp;
    logic               nan;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [16:0]        depth;
  } point_t;

  typedef struct {
    pixel_t px;
    bit     typed;
    bit     hit;
    point_t pt;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [11:0] region_row_i = '0;
  logic [11:0] region_col_i = '0;
  logic [7:0] mask_value_i = '0;
  logic signed [15:0] disparity_raw_i = '0;
  logic disparity_nan_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [23:0] x_mm_o;
  logic signed [23:0] y_mm_o;
  logic [16:0] depth_mm_o;

  disparity_to_point_cloud_core uut (.*);

  always #5 clk_i = ~clk_i;

  // model copy of the registers
  logic [7:0]  step_r;
  logic [11:0] left_r, top_r;
  logic [15:0] fx_r, fy_r, cx_r, cy_r, base_r;

  point_t pending_points[$];
  int errors = 0;
  int pixels_sent = 0;
  int points_checked = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  row_t dir_rows[14];

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic bit project_pixel(input pixel_t p, output point_t pt);
    longint step, disp, num, den, dep, ci, ri, nx, ny;
    pt = '0;
    step = (step_r < 2) ? 2 : longint'(step_r);
    if ((longint'(p.row) % step) != 0 || (longint'(p.col) % step) != 0) return 1'b0;
    if (p.mask == 0 || p.nan) return 1'b0;
    disp = longint'(p.disp);
    if (disp <= 0) return 1'b0;
    num = (longint'(fx_r) * longint'(base_r)) << 4;
    den = disp << 4;
    dep = num / den;
    if (dep <= 100 || dep > 100000) return 1'b0;
    ci = longint'(p.col) + longint'(left_r);
    ri = longint'(p.row) + longint'(top_r);
    nx = (ci * 16 - longint'(cx_r)) * dep;
    ny = (ri * 16 - longint'(cy_r)) * dep;
    pt.x = clamp24(nx / longint'(fx_r));
    if (fy_r == 0) pt.y = (ny > 0) ? 24'sh7FFFFF : (ny < 0) ? 24'sh800000 : 24'sh0;
    else pt.y = clamp24(ny / longint'(fy_r));
    pt.depth = dep[16:0];
    return 1'b1;
  endfunction

  function automatic void queue_point(input point_t pt);
    pending_points = {pending_points, pt};
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic load_registers(input logic [15:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= dtpc_pkg::reg_e'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      case (dtpc_pkg::reg_e'(i))
        dtpc_pkg::RegStep:     step_r = v[i][7:0];
        dtpc_pkg::RegLeft:     left_r = v[i][11:0];
        dtpc_pkg::RegTop:      top_r  = v[i][11:0];
        dtpc_pkg::RegFocalX:   fx_r   = v[i];
        dtpc_pkg::RegFocalY:   fy_r   = v[i];
        dtpc_pkg::RegCenterX:  cx_r   = v[i];
        dtpc_pkg::RegCenterY:  cy_r   = v[i];
        dtpc_pkg::RegBaseline: base_r = v[i];
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // send one pixel; returns once accepted
  task automatic send_pixel(input pixel_t p);
    if (!calm && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    region_row_i <= p.row;
    region_col_i <= p.col;
    mask_value_i <= p.mask;
    disparity_raw_i <= p.disp;
    disparity_nan_i <= p.nan;
    do @(posedge clk_i); while (full);
    pixels_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    longint step, fb, d, dp;
    p.row = 12'($urandom); p.col = 12'($urandom); p.mask = 8'($urandom);
    p.disp = 16'($urandom); p.nan = 1'($urandom);
    if ($urandom_range(99) < 75) begin
      step = (step_r < 2) ? 2 : longint'(step_r);
      p.row = 12'(step * $urandom_range(4095 / step));
      p.col = 12'(step * $urandom_range(4095 / step));
      p.mask = 8'($urandom_range(1, 255));
      p.nan = 1'b0;
      fb = longint'(fx_r) * longint'(base_r);
      d = $urandom_range(101, 100000);
      dp = fb / d;
      if (dp < 1) dp = 1;
      if (dp > 32767) dp = 32767;
      if ($urandom_range(9) == 0) dp = dp + $urandom_range(3) - 1;
      p.disp = dp[15:0];
    end
    return p;
  endfunction

  always @(posedge clk_i) pop <= calm ? 1'b1 : ($urandom_range(99) >= 26);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("disparity_to_point_cloud_core: mismatch");
        $finish;
      end
      if (pop && !empty) begin
        if (pending_points.size() == 0) begin
          report("unexpected point, depth", depth_mm_o, 0);
        end else begin
          point_t w;
          w = pending_points.pop_front();
          points_checked++;
          if (x_mm_o !== w.x) report("x_mm", x_mm_o, w.x);
          if (y_mm_o !== w.y) report("y_mm", y_mm_o, w.y);
          if (depth_mm_o !== w.depth) report("depth_mm", depth_mm_o, w.depth);
        end
      end
    end
  end

  initial begin
    logic [15:0] regs[8];
    point_t pt;
    pixel_t p;
    int n;
    step_r = 2; left_r = 0; top_r = 0; fx_r = 8000; fy_r = 8000;
    cx_r = 5120; cy_r = 3840; base_r = 120;
    dir_rows[0]  = '{'{12'd0, 12'd0, 8'd1, 16'sd16, 1'b0}, 1, 1,
                     '{-24'sd38400, -24'sd28800, 17'd60000}};
    dir_rows[1]  = '{'{12'd0, 12'd0, 8'd1, 16'sd16, 1'b1}, 1, 0, '0};
    dir_rows[2]  = '{'{12'd0, 12'd0, 8'd0, 16'sd16, 1'b0}, 1, 0, '0};
    dir_rows[3]  = '{'{12'd2, 12'd2, 8'd5, 16'sd0, 1'b0}, 1, 0, '0};
    dir_rows[4]  = '{'{12'd2, 12'd2, 8'd5, -16'sd32768, 1'b0}, 1, 0, '0};
    dir_rows[5]  = '{'{12'd2, 12'd2, 8'd5, -16'sd1, 1'b0}, 1, 0, '0};
    dir_rows[6]  = '{'{12'd1, 12'd0, 8'd5, 16'sd16, 1'b0}, 1, 0, '0};
    dir_rows[7]  = '{'{12'd0, 12'd3, 8'd5, 16'sd16, 1'b0}, 1, 0, '0};
    dir_rows[8]  = '{'{12'd4, 12'd4, 8'd5, 16'sd32767, 1'b0}, 1, 0, '0};
    dir_rows[9]  = '{'{12'd4, 12'd4, 8'd5, 16'sd9, 1'b0}, 1, 0, '0};
    dir_rows[10] = '{'{12'd6, 12'd8, 8'd5, 16'sd10, 1'b0}, 0, 0, '0};
    dir_rows[11] = '{'{12'd4094, 12'd4094, 8'd255, 16'sd16, 1'b0}, 0, 0, '0};
    dir_rows[12] = '{'{12'd8, 12'd8, 8'd7, 16'sd9600, 1'b0}, 1, 0, '0};
    dir_rows[13] = '{'{12'd8, 12'd8, 8'd7, 16'sd9504, 1'b0}, 0, 0, '0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].px);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].hit) queue_point(dir_rows[i].pt);
      end else if (project_pixel(dir_rows[i].px, pt)) begin
        queue_point(pt);
      end
    end
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: regs = '{16'd2, 16'd0, 16'd0, 16'd8000, 16'd8000, 16'd5120, 16'd3840, 16'd120};
        1: regs = '{16'd255, 16'd4095, 16'd4095, 16'd65535, 16'd65535, 16'd0, 16'd0,
                    16'd65535};
        2: regs = '{16'd0, 16'd100, 16'd50, 16'd5000, 16'd0, 16'd65535, 16'd65535, 16'd200};
        3: regs = '{16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd65535, 16'd65535};
        4: regs = '{16'd3, 16'd10, 16'd10, 16'd0, 16'd6000, 16'd100, 16'd100, 16'd0};
        default: begin
          regs[0] = 16'($urandom_range(2, 7));
          for (int i = 1; i < 8; i++) regs[i] = 16'($urandom);
          regs[dtpc_pkg::RegFocalX] = 16'($urandom_range(1, 65535));
          regs[dtpc_pkg::RegBaseline] = 16'($urandom_range(1, 65535));
        end
      endcase
      load_registers(regs);
      calm = (ph == 5);
      n = (ph == 4) ? 20 : 155;
      for (int k = 0; k < n; k++) begin
        p = random_pixel();
        send_pixel(p);
        if (project_pixel(p, pt)) queue_point(pt);
        if (ph == 0 && k == 80) drain();
      end
      drain();
    end
    calm = 1'b0;

    $display("sent %0d pixels over 7 register settings, %0d points checked",
             pixels_sent, points_checked);
    if (errors == 0) begin
      $display("disparity_to_point_cloud_core: match");
    end else begin
      $display("disparity_to_point_cloud_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
sv/dtpc_pkg.sv
sv/dtpc_front.sv
sv/dtpc_fifo.sv
sv/dtpc_back.sv
sv/disparity_to_point_cloud_core.sv
bench/disparity_to_point_cloud_core_test.sv
